[rtl/core/ufd_pkg.sv]
package ufd_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 2;

  // header is version, type, tag, payload size: four big-endian words
  localparam logic [3:0] HDR_LAST_IDX = 4'd15;
  localparam logic [3:0] HDR_TYPE_IDX = 4'd7;
  localparam logic [3:0] LEN_BYTES = 4'd4;
  localparam logic [WordW-1:0] LEN_FIELD_BYTES = 32'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DATA_TYPE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HB_TYPE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN = 2'd2;

  localparam logic [WordW-1:0] DATA_TYPE_RST = 32'd200;
  localparam logic [WordW-1:0] HB_TYPE_RST = 32'd201;
  localparam logic [WordW-1:0] MAX_LEN_RST = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_EMPTY = 3'd1,
    ST_HEARTBEAT = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_SHORT = 3'd4,
    ST_EXCEEDS = 3'd5,
    ST_TOO_LARGE = 3'd6
  } status_t;

  typedef struct packed {
    logic [WordW-1:0] data_type;
    logic [WordW-1:0] hb_type;
    logic [WordW-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic is_msg;
    logic [DataW-1:0] data;
    logic last;
    logic fend;
    status_t status;
  } result_t;

endpackage

[rtl/core/usb_frame_deframer.sv]
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | in_stream_byte[7:0]
// out_    | output    | out_valid/out_stall | is_message_byte, message_data[7:0],
//         |           |                     | message_last, frame_end, frame_status[2:0]
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[31:0]
//
// one byte per cycle sustained while out_stall is low; a byte goes input register ->
// parser -> result register, and out_valid rises when the result register is loaded
// bytes that only advance the header, length or skip counters give no result transfer
// synchronous active-low reset returns to the header phase and restores the register
// defaults; cfg writes are always accepted, as cfg_ready is tied high
// while a result waits under out_stall the input register takes one more byte, then
// in_stall follows out_stall until the result slot frees, even for bytes that owe nothing
module usb_frame_deframer
  import ufd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DataW-1:0]   in_stream_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_message_byte,
  output logic [DataW-1:0]   out_message_data,
  output logic               out_message_last,
  output logic               out_frame_end,
  output logic [2:0]         out_frame_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [WordW-1:0]   cfg_data
);

  logic             byte_vld;
  logic [DataW-1:0] byte_q;
  logic             slot_free;
  logic             advance;
  logic             res_vld;
  result_t          res;
  result_t          res_q;
  cfg_t             cfg_r;

  // the parser steps whenever a byte is held and the result slot can take its result
  assign advance = byte_vld && slot_free;
  assign cfg_ready = 1'b1;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_type <= DATA_TYPE_RST;
      cfg_r.hb_type <= HB_TYPE_RST;
      cfg_r.max_len <= MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DATA_TYPE) cfg_r.data_type <= cfg_data;
      if (cfg_index == CFG_HB_TYPE) cfg_r.hb_type <= cfg_data;
      if (cfg_index == CFG_MAX_LEN) cfg_r.max_len <= cfg_data;
    end
  end

  ufd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_stream_byte),
    .in_stall (in_stall),
    .advance  (advance),
    .byte_vld (byte_vld),
    .byte_out (byte_q)
  );

  ufd_parser u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (byte_q),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  ufd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_vld),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .slot_free (slot_free),
    .res_out   (res_q)
  );

  assign out_is_message_byte = res_q.is_msg;
  assign out_message_data = res_q.data;
  assign out_message_last = res_q.last;
  assign out_frame_end = res_q.fend;
  assign out_frame_status = res_q.status;

endmodule

[rtl/core/ufd_in_stage.sv]
module ufd_in_stage
  import ufd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DataW-1:0] in_byte,
  output logic             in_stall,
  input  logic             advance,
  output logic             byte_vld,
  output logic [DataW-1:0] byte_out
);

  logic             vld_r;
  logic [DataW-1:0] byte_r;

  // holding register frees up in the same cycle it is consumed
  assign in_stall = vld_r && !advance;
  assign byte_vld = vld_r;
  assign byte_out = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte;
    end
  end

endmodule

[rtl/core/ufd_parser.sv]
module ufd_parser
  import ufd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic [DataW-1:0] byte_in,
  input  cfg_t             cfg,
  output logic             res_vld,
  output result_t          res
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_MESSAGE = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       idx_r, idx_nxt;
  logic [WordW-1:0] shift_r, shift_nxt;
  logic [WordW-1:0] kind_r, kind_nxt;
  logic [WordW-1:0] pay_r, pay_nxt;
  logic [WordW-1:0] msg_r, msg_nxt;
  status_t          pend_r, pend_nxt;

  logic [WordW-1:0] shifted;
  logic [WordW-1:0] pay_dec;
  logic [WordW-1:0] msg_dec;
  logic [3:0]       idx_inc;
  status_t          eos_st;
  logic             eos;

  assign shifted = {shift_r[WordW-DataW-1:0], byte_in};
  assign pay_dec = (pay_r != '0) ? pay_r - 1'b1 : pay_r;
  assign msg_dec = (msg_r != '0) ? msg_r - 1'b1 : msg_r;
  assign idx_inc = idx_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt = idx_r;
    shift_nxt = shift_r;
    kind_nxt = kind_r;
    pay_nxt = pay_r;
    msg_nxt = msg_r;
    pend_nxt = pend_r;
    res_vld = 1'b0;
    res = '{is_msg: 1'b0, data: '0, last: 1'b0, fend: 1'b0, status: ST_DELIVERED};
    eos = 1'b0;
    eos_st = ST_DELIVERED;

    unique case (phase_r)
      PH_HEADER: begin
        shift_nxt = shifted;
        if (idx_r == HDR_TYPE_IDX) kind_nxt = shifted;
        if (idx_r != HDR_LAST_IDX) begin
          idx_nxt = idx_inc;
        end else begin
          idx_nxt = '0;
          pay_nxt = shifted;
          if (kind_r == cfg.data_type) begin
            if (shifted < LEN_FIELD_BYTES) begin
              eos = 1'b1;
              eos_st = ST_SHORT;
            end else begin
              phase_nxt = PH_LENGTH;
              shift_nxt = '0;
            end
          end else begin
            eos = 1'b1;
            eos_st = (kind_r == cfg.hb_type) ? ST_HEARTBEAT : ST_UNKNOWN;
          end
        end
      end
      PH_LENGTH: begin
        shift_nxt = shifted;
        pay_nxt = pay_dec;
        idx_nxt = idx_inc;
        if (idx_inc == LEN_BYTES) begin
          idx_nxt = '0;
          // remaining payload already excludes the length field, no wrap
          priority if (shifted > pay_dec) begin
            eos = 1'b1;
            eos_st = ST_EXCEEDS;
          end else if (shifted > cfg.max_len) begin
            eos = 1'b1;
            eos_st = ST_TOO_LARGE;
          end else if (shifted == '0) begin
            eos = 1'b1;
            eos_st = ST_EMPTY;
          end else begin
            msg_nxt = shifted;
            phase_nxt = PH_MESSAGE;
          end
        end
      end
      PH_MESSAGE: begin
        pay_nxt = pay_dec;
        msg_nxt = msg_dec;
        res_vld = 1'b1;
        res.is_msg = 1'b1;
        res.data = byte_in;
        if (msg_dec == '0) begin
          res.last = 1'b1;
          if (pay_dec == '0) begin
            res.fend = 1'b1;
            phase_nxt = PH_HEADER;
            pend_nxt = ST_DELIVERED;
          end else begin
            phase_nxt = PH_SKIP;
            pend_nxt = ST_DELIVERED;
          end
        end
      end
      PH_SKIP: begin
        pay_nxt = pay_dec;
        if (pay_dec == '0) begin
          res_vld = 1'b1;
          res.fend = 1'b1;
          res.status = pend_r;
          phase_nxt = PH_HEADER;
          pend_nxt = ST_DELIVERED;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    // end the frame now or skip what is left of the payload
    if (eos) begin
      if (pay_nxt == '0) begin
        phase_nxt = PH_HEADER;
        pend_nxt = ST_DELIVERED;
        res_vld = 1'b1;
        res.fend = 1'b1;
        res.status = eos_st;
      end else begin
        phase_nxt = PH_SKIP;
        pend_nxt = eos_st;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      idx_r <= '0;
      shift_r <= '0;
      kind_r <= '0;
      pay_r <= '0;
      msg_r <= '0;
      pend_r <= ST_DELIVERED;
    end else if (advance) begin
      phase_r <= phase_nxt;
      idx_r <= idx_nxt;
      shift_r <= shift_nxt;
      kind_r <= kind_nxt;
      pay_r <= pay_nxt;
      msg_r <= msg_nxt;
      pend_r <= pend_nxt;
    end
  end

  a_len_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LENGTH |-> idx_r < LEN_BYTES)
    else $error("length index out of range");

  a_msg_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MESSAGE |-> msg_r != '0)
    else $error("message phase with nothing left");

  a_skip_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> pay_r != '0)
    else $error("skip phase with empty payload");

  a_end_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_vld && res.fend |=> phase_r == PH_HEADER && idx_r == '0)
    else $error("frame end not followed by header");

endmodule

[rtl/core/ufd_out_stage.sv]
module ufd_out_stage
  import ufd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    slot_free,
  output result_t res_out
);

  logic    vld_r;
  result_t res_r;

  // slot takes a new result in the cycle the old one leaves
  assign slot_free = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign res_out = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (slot_free) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load) begin
      res_r <= res_in;
    end
  end

endmodule
